// ===== rtl/core/scaled_rect_and_text_rasterizer_top_assert.svh =====
// assertion macros for the rasterizer
`ifndef SCALED_RECT_AND_TEXT_RASTERIZER_TOP_ASSERT_SVH
`define SCALED_RECT_AND_TEXT_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define SRT_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/srt_pkg.sv =====
// shared types, constants and glyph table of the rasterizer
package srt_pkg;

  localparam int FB_WIDTH = 640;
  localparam int FB_HEIGHT = 480;
  localparam int CELL_SIZE = 8;
  localparam int STORE_WORDS = FB_WIDTH * FB_HEIGHT / 2;
  localparam int STORE_AW = $clog2(STORE_WORDS);
  localparam int IDX_W = STORE_AW + 1;

  localparam int SPAN_W = 11;
  localparam int COORD_W = 13;
  localparam int SIZE_W = 10;
  localparam int READ_IDX_W = 18;
  localparam int MAX_DIM = (FB_WIDTH > FB_HEIGHT) ? FB_WIDTH : FB_HEIGHT;
  localparam int SCALE_W = $clog2(MAX_DIM + 1);
  localparam int PROD_W = COORD_W + SCALE_W + 1;
  localparam int MAG_W = PROD_W - 1;
  localparam int PX_W = $clog2(FB_WIDTH + 1);
  localparam int PY_W = $clog2(FB_HEIGHT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int GLYPH_BITS = 35;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y = 1'b1;
  localparam logic [SPAN_W-1:0] SPAN_X_RESET = 11'd320;
  localparam logic [SPAN_W-1:0] SPAN_Y_RESET = 11'd240;

  localparam logic [7:0] INK_Y_WHITE = 8'd235;
  localparam logic [7:0] INK_Y_BLACK = 8'd16;
  localparam logic [7:0] CHROMA_MID = 8'h80;
  localparam logic [15:0] HALF_CLEAR_BLACK = 16'h0080;
  localparam logic [15:0] HALF_CLEAR_WHITE = 16'hFF80;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_RECT = 2'd1,
    KIND_CHAR = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ_MEM,
    ST_READ_OUT,
    ST_GLYPH,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CLIP,
    ST_RASTER
  } state_t;

  typedef struct packed {
    kind_t kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic white;
    logic with_bg;
    logic [7:0] code;
    logic [READ_IDX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic [MAG_W-1:0] mag;
    logic [SPAN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic neg;
    logic [MAG_W-1:0] mag;
  } div_rsp_t;

  // top bit flags a known code, rows top first, msb of each row leftmost
  function automatic logic [GLYPH_BITS:0] glyph_lookup(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] g;
    logic ok;
    ok = 1'b1;
    case (code)
      8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'h31: g = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h32: g = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      8'h33: g = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h34: g = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      8'h36: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'h37: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      8'h2B: g = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
      8'h2D: g = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      8'h25: g = {5'd17, 5'd2, 5'd4, 5'd4, 5'd8, 5'd16, 5'd17};
      8'h2F: g = {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
      8'h3A: g = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      8'h2E: g = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
      8'h41, 8'h61: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h42, 8'h62: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'h43, 8'h63: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      8'h44, 8'h64: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      8'h45, 8'h65: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'h46, 8'h66: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h47, 8'h67: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      8'h48, 8'h68: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h49, 8'h69: g = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      8'h4A, 8'h6A: g = {5'd7, 5'd2, 5'd2, 5'd2, 5'd18, 5'd18, 5'd12};
      8'h4B, 8'h6B: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      8'h4C, 8'h6C: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'h4D, 8'h6D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'h4E, 8'h6E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'h4F, 8'h6F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h50, 8'h70: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h51, 8'h71: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      8'h52, 8'h72: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'h53, 8'h73: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      8'h54, 8'h74: g = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h55, 8'h75: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h56, 8'h76: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd10, 5'd4};
      8'h57, 8'h77: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      8'h58, 8'h78: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      8'h59, 8'h79: g = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      8'h5A, 8'h7A: g = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      default: begin
        g = '0;
        ok = 1'b0;
      end
    endcase
    return {ok, g};
  endfunction

endpackage

// ===== rtl/core/srt_cmd_if.sv =====
// command channel carrying one drawing or read item
interface srt_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic [9:0] rect_width;
  logic [9:0] rect_height;
  logic ink_white;
  logic [6:0] cell_column;
  logic [5:0] cell_row;
  logic [7:0] char_code;
  logic with_background;
  logic [17:0] read_index;

  modport source (
    output valid, kind, pos_x, pos_y, rect_width, rect_height, ink_white,
           cell_column, cell_row, char_code, with_background, read_index,
    input ready
  );
  modport sink (
    input valid, kind, pos_x, pos_y, rect_width, rect_height, ink_white,
          cell_column, cell_row, char_code, with_background, read_index,
    output ready
  );
endinterface

// ===== rtl/core/srt_rd_if.sv =====
// result channel carrying one pair word
interface srt_rd_if;
  logic valid;
  logic ready;
  logic [31:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ===== rtl/core/srt_front.sv =====
// command intake, classification and command queue
module srt_front (
  input  logic           clk,
  input  logic           rst,
  srt_cmd_if.sink        cmd,
  output logic           q_valid,
  output srt_pkg::cmd_t  q_cmd,
  input  logic           q_pop
);
  import srt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t classified;
  logic push;

  always_comb begin
    classified.kind = kind_t'(cmd.kind);
    classified.white = cmd.ink_white;
    classified.with_bg = cmd.with_background;
    classified.code = cmd.char_code;
    classified.index = cmd.read_index;
    if (kind_t'(cmd.kind) == KIND_CHAR) begin
      classified.x = $signed(COORD_W'(cmd.cell_column) * COORD_W'(CELL_SIZE));
      classified.y = $signed(COORD_W'(cmd.cell_row) * COORD_W'(CELL_SIZE));
      classified.w = SIZE_W'(CELL_SIZE);
      classified.h = SIZE_W'(CELL_SIZE);
    end else begin
      classified.x = COORD_W'(cmd.pos_x);
      classified.y = COORD_W'(cmd.pos_y);
      classified.w = cmd.rect_width;
      classified.h = cmd.rect_height;
    end
  end

  assign cmd.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push = cmd.valid && cmd.ready;
  assign q_valid = (count != '0);
  assign q_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/srt_div.sv =====
// radix-2 restoring divider for coordinate scaling
module srt_div (
  input  logic              clk,
  input  logic              rst,
  input  srt_pkg::div_req_t req,
  output srt_pkg::div_rsp_t rsp
);
  import srt_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic busy;
  logic done;
  logic neg;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] work;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] den;
  logic [SPAN_W:0] trial;
  logic fits;

  assign trial = {rem, work[MAG_W-1]};
  assign fits = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.mag;
      rem <= '0;
      den <= req.den;
      neg <= req.neg;
      cnt <= '0;
    end else if (busy) begin
      rem <= fits ? SPAN_W'(trial - {1'b0, den}) : trial[SPAN_W-1:0];
      work <= {work[MAG_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.neg = neg;
  assign rsp.mag = work;

endmodule

// ===== rtl/core/srt_back.sv =====
// command execution: clear, scaled fill, glyph walk, read, frame store
`include "scaled_rect_and_text_rasterizer_top_assert.svh"

module srt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srt_pkg::SPAN_W-1:0]     cfg_data,
  input  logic                           q_valid,
  input  srt_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output srt_pkg::div_req_t              div_req,
  input  srt_pkg::div_rsp_t              div_rsp,
  srt_rd_if.source                       rd
);
  import srt_pkg::*;

  state_t state;
  state_t state_next;

  logic [SPAN_W-1:0] span_x;
  logic [SPAN_W-1:0] span_y;
  cmd_t cur;

  logic signed [COORD_W-1:0] rx;
  logic signed [COORD_W-1:0] ry;
  logic [SIZE_W-1:0] rw;
  logic [SIZE_W-1:0] rh;
  logic rwhite;

  logic bg_pending;
  logic glyph_ok;
  logic [GLYPH_BITS-1:0] glyph_sr;
  logic [2:0] gx;
  logic [2:0] gy;
  logic [GLYPH_BITS:0] glyph_in;

  logic [1:0] div_sel;
  logic div_start;
  logic signed [PROD_W-1:0] qx0, qx1, qy0, qy1;
  logic signed [PROD_W-1:0] quot;
  logic signed [COORD_W-1:0] num_base;
  logic signed [PROD_W-1:0] prod;
  logic [SPAN_W-1:0] span_sel;

  logic signed [PROD_W-1:0] cx0, cx1, cy0, cy1;
  logic clip_empty;

  logic [PX_W-1:0] px, x0, x1;
  logic [PY_W-1:0] py, y1;
  logic row_end, col_end;
  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] pix_idx;
  logic [STORE_AW-1:0] clr_idx;

  logic [15:0] mem_hi [STORE_WORDS];
  logic [15:0] mem_lo [STORE_WORDS];
  logic we_hi, we_lo;
  logic [STORE_AW-1:0] waddr;
  logic [15:0] wdata;
  logic [15:0] rd_hi, rd_lo;
  logic rd_in_range;

  logic out_valid;
  logic [31:0] out_data;
  logic out_load;
  logic rect_empty_in;
  logic glyph_fire;
  logic glyph_done;

  assign glyph_in = glyph_lookup(q_cmd.code);
  assign rect_empty_in = (q_cmd.w == '0) || (q_cmd.h == '0);
  assign glyph_done = !glyph_ok || (gy == 3'd7);
  assign glyph_fire = !bg_pending && !glyph_done && glyph_sr[GLYPH_BITS-1];

  // numerator and divisor for the current scaling step
  always_comb begin
    unique case (div_sel)
      2'd0: num_base = rx;
      2'd1: num_base = rx + $signed({{(COORD_W - SIZE_W){1'b0}}, rw});
      2'd2: num_base = ry;
      default: num_base = ry + $signed({{(COORD_W - SIZE_W){1'b0}}, rh});
    endcase
    if (div_sel[1]) begin
      prod = num_base * $signed({1'b0, SCALE_W'(FB_HEIGHT)});
      span_sel = span_y;
    end else begin
      prod = num_base * $signed({1'b0, SCALE_W'(FB_WIDTH)});
      span_sel = span_x;
    end
  end

  assign div_req.start = div_start;
  assign div_req.neg = prod[PROD_W-1];
  assign div_req.mag = prod[PROD_W-1] ? MAG_W'(-prod) : prod[MAG_W-1:0];
  assign div_req.den = (span_sel == '0) ? SPAN_W'(1) : span_sel;
  assign quot = div_rsp.neg ? -$signed({1'b0, div_rsp.mag}) : $signed({1'b0, div_rsp.mag});

  always_comb begin
    cx0 = (qx0 < 0) ? '0 : qx0;
    cy0 = (qy0 < 0) ? '0 : qy0;
    cx1 = (qx1 > PROD_W'(FB_WIDTH)) ? PROD_W'(FB_WIDTH) : qx1;
    cy1 = (qy1 > PROD_W'(FB_HEIGHT)) ? PROD_W'(FB_HEIGHT) : qy1;
    clip_empty = (cx0 >= cx1) || (cy0 >= cy1);
  end

  assign col_end = (PX_W'(px + 1'b1) == x1);
  assign row_end = (PY_W'(py + 1'b1) == y1);
  assign row_base = IDX_W'((IDX_W'(py) * IDX_W'(FB_WIDTH)) >> 1);
  assign pix_idx = row_base + IDX_W'(px >> 1);
  assign rd_in_range = (32'(cur.index) < 32'(STORE_WORDS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            KIND_CLEAR: state_next = ST_CLEAR;
            KIND_RECT: state_next = rect_empty_in ? ST_IDLE : ST_DIV_START;
            KIND_CHAR: state_next = ST_GLYPH;
            KIND_READ: state_next = ST_READ_MEM;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_idx == STORE_AW'(STORE_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_READ_MEM: state_next = ST_READ_OUT;
      ST_READ_OUT: begin
        if (!out_valid || rd.ready) state_next = ST_IDLE;
      end
      ST_GLYPH: begin
        if (bg_pending || glyph_fire) state_next = ST_DIV_START;
        else if (glyph_done) state_next = ST_IDLE;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) state_next = (div_sel == 2'd3) ? ST_CLIP : ST_DIV_START;
      end
      ST_CLIP: begin
        if (!clip_empty) state_next = ST_RASTER;
        else state_next = (cur.kind == KIND_CHAR) ? ST_GLYPH : ST_IDLE;
      end
      ST_RASTER: begin
        if (col_end && row_end) state_next = (cur.kind == KIND_CHAR) ? ST_GLYPH : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    div_start = 1'b0;
    we_hi = 1'b0;
    we_lo = 1'b0;
    waddr = clr_idx;
    wdata = cur.white ? HALF_CLEAR_WHITE : HALF_CLEAR_BLACK;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      ST_CLEAR: begin
        we_hi = 1'b1;
        we_lo = 1'b1;
      end
      ST_READ_OUT: out_load = !out_valid || rd.ready;
      ST_DIV_START: div_start = 1'b1;
      ST_RASTER: begin
        waddr = pix_idx[STORE_AW-1:0];
        wdata = {rwhite ? INK_Y_WHITE : INK_Y_BLACK, CHROMA_MID};
        if (pix_idx < IDX_W'(STORE_WORDS)) begin
          we_hi = !px[0];
          we_lo = px[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_hi) mem_hi[waddr] <= wdata;
    if (we_lo) mem_lo[waddr] <= wdata;
    rd_hi <= mem_hi[STORE_AW'(cur.index)];
    rd_lo <= mem_lo[STORE_AW'(cur.index)];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur <= q_cmd;
        rx <= q_cmd.x;
        ry <= q_cmd.y;
        rw <= q_cmd.w;
        rh <= q_cmd.h;
        rwhite <= q_cmd.white;
        bg_pending <= q_cmd.with_bg;
        glyph_ok <= glyph_in[GLYPH_BITS];
        glyph_sr <= glyph_in[GLYPH_BITS-1:0];
        gx <= '0;
        gy <= '0;
        div_sel <= '0;
        clr_idx <= '0;
      end
      ST_CLEAR: clr_idx <= clr_idx + 1'b1;
      ST_GLYPH: begin
        div_sel <= '0;
        if (bg_pending) begin
          bg_pending <= 1'b0;
          rx <= cur.x;
          ry <= cur.y;
          rw <= cur.w;
          rh <= cur.h;
          rwhite <= !cur.white;
        end else if (!glyph_done) begin
          glyph_sr <= {glyph_sr[GLYPH_BITS-2:0], 1'b0};
          rx <= cur.x + $signed(COORD_W'(gx)) + COORD_W'(1);
          ry <= cur.y + $signed(COORD_W'(gy));
          rw <= SIZE_W'(1);
          rh <= SIZE_W'(1);
          rwhite <= cur.white;
          if (gx == 3'd4) begin
            gx <= '0;
            gy <= gy + 1'b1;
          end else begin
            gx <= gx + 1'b1;
          end
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (div_sel)
            2'd0: qx0 <= quot;
            2'd1: qx1 <= quot;
            2'd2: qy0 <= quot;
            default: qy1 <= quot;
          endcase
          div_sel <= div_sel + 1'b1;
        end
      end
      ST_CLIP: begin
        px <= cx0[PX_W-1:0];
        x0 <= cx0[PX_W-1:0];
        x1 <= cx1[PX_W-1:0];
        py <= cy0[PY_W-1:0];
        y1 <= cy1[PY_W-1:0];
      end
      ST_RASTER: begin
        if (col_end) begin
          px <= x0;
          py <= py + 1'b1;
        end else begin
          px <= px + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      span_x <= SPAN_X_RESET;
      span_y <= SPAN_Y_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == CFG_SPAN_X) span_x <= cfg_data;
      if (cfg_we && cfg_index == CFG_SPAN_Y) span_y <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (rd.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= rd_in_range ? {rd_hi, rd_lo} : 32'd0;
  end

  assign rd.valid = out_valid;
  assign rd.read_data = out_data;

  `SRT_ASSERT(a_pop_when_idle, clk, rst, q_pop, state == ST_IDLE && q_valid, "pop outside idle")
  `SRT_ASSERT(a_div_start_free, clk, rst, div_start, !div_rsp.busy, "divider restarted while busy")
  `SRT_ASSERT(a_raster_bounds, clk, rst, state == ST_RASTER, px < x1 && py < y1 && x0 < x1, "raster walk out of bounds")

endmodule

// ===== rtl/core/scaled_rect_and_text_rasterizer_top.sv =====
// top level of the scaled rectangle and text rasterizer
//
// channel  dir  handshake      payload
// cmd      in   valid/ready    kind, pos, size, ink, cell, code, background, index
// rd       out  valid/ready    read_data (pair word)
// cfg      in   cfg_we only    cfg_index, cfg_data (logical spans)
//
// clear writes one pair word per cycle (153600 at 640x480)
// a rectangle takes four scaling divides, then one pixel per cycle
// a character walks 35 glyph bits, each set bit is a one-pixel-scale fill
// a read passes through ST_READ_MEM and ST_READ_OUT; a two-entry command queue decouples intake from the drawing engine
// synchronous reset clears control state only; frame store holds garbage until written
module scaled_rect_and_text_rasterizer_top (
  input  logic                          clk,
  input  logic                          rst,
  srt_cmd_if.sink                       cmd,
  srt_rd_if.source                      rd,
  input  logic                          cfg_we,
  input  logic [srt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srt_pkg::SPAN_W-1:0]    cfg_data
);
  import srt_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  srt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  srt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  srt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rd        (rd)
  );

endmodule
